// ===== hw/rtl/rc5_pkg.sv =====
`timescale 1ns / 1ps

package rc5_pkg;

  // one sampling tick as it enters the receiver
  typedef struct packed {
    logic pin_level;
    logic falling_edge;
    logic read_ack;
  } item_t;

  // timing registers, all in ticks
  typedef struct packed {
    logic [5:0] initial_wait;
    logic [5:0] half_bit_wait;
    logic [5:0] bit_wait;
  } cfg_t;

  typedef struct packed {
    logic       frame_event;
    logic [5:0] command;
    logic [4:0] address;
    logic       toggle_bit;
    logic       new_data;
    logic       busy_res;
  } result_t;

  typedef enum logic [1:0] {
    REG_INITIAL_WAIT  = 2'd0,
    REG_HALF_BIT_WAIT = 2'd1,
    REG_BIT_WAIT      = 2'd2
  } reg_idx_t;

  localparam int unsigned FRAME_W = 12;
  localparam logic [3:0] FRAME_BITS = 4'd12;
  localparam logic [5:0] END_WAIT = 6'd20;

  localparam logic [5:0] INITIAL_WAIT_RST  = 6'd22;
  localparam logic [5:0] HALF_BIT_WAIT_RST = 6'd8;
  localparam logic [5:0] BIT_WAIT_RST      = 6'd18;

endpackage

// ===== hw/rtl/rc5_cfg_regs.sv =====
`timescale 1ns / 1ps

module rc5_cfg_regs
  import rc5_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_wait  <= INITIAL_WAIT_RST;
      cfg.half_bit_wait <= HALF_BIT_WAIT_RST;
      cfg.bit_wait      <= BIT_WAIT_RST;
    end else if (cfg_valid) begin
      // writes to an index beyond the register list are dropped
      unique case (cfg_index)
        REG_INITIAL_WAIT:  cfg.initial_wait  <= cfg_data;
        REG_HALF_BIT_WAIT: cfg.half_bit_wait <= cfg_data;
        REG_BIT_WAIT:      cfg.bit_wait      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rc5_in_stage.sv =====
`timescale 1ns / 1ps

module rc5_in_stage
  import rc5_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  input  logic  item_take,
  output item_t item
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= (in_valid && in_ready) || (item_valid && !item_take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== hw/rtl/rc5_core.sv =====
`timescale 1ns / 1ps

module rc5_core
  import rc5_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  output logic    item_take,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic               armed;
  logic               armed_next;
  logic [5:0]         wait_count;
  logic [5:0]         wait_count_next;
  logic               started;
  logic               started_next;
  logic [3:0]         bit_index;
  logic [3:0]         bit_index_next;
  logic [FRAME_W-1:0] shift_word;
  logic [FRAME_W-1:0] shift_word_next;
  logic [FRAME_W-1:0] stored_frame;
  logic [FRAME_W-1:0] stored_frame_next;
  logic               new_flag;
  logic               new_flag_next;
  logic               event_next;

  assign item_take = item_valid && (!res_valid || res_ready);

  always_comb begin
    armed_next        = armed;
    wait_count_next   = wait_count;
    started_next      = started;
    bit_index_next    = bit_index;
    shift_word_next   = shift_word;
    stored_frame_next = stored_frame;
    new_flag_next     = item.read_ack ? 1'b0 : new_flag;
    event_next        = 1'b0;
    priority if (!armed) begin
      if (item.falling_edge) begin
        armed_next      = 1'b1;
        wait_count_next = cfg.initial_wait;
      end
    end else if (wait_count > 6'd1) begin
      wait_count_next = wait_count - 6'd1;
    end else if (!started) begin
      // high start sample means the edge was noise
      if (item.pin_level) begin
        armed_next      = 1'b0;
        wait_count_next = cfg.initial_wait;
      end else begin
        wait_count_next = cfg.half_bit_wait;
        started_next    = 1'b1;
        bit_index_next  = 4'd0;
        shift_word_next = '0;
      end
    end else if (bit_index < FRAME_BITS) begin
      shift_word_next = {shift_word[FRAME_W-2:0], item.pin_level};
      wait_count_next = cfg.bit_wait;
      bit_index_next  = bit_index + 4'd1;
    end else begin
      armed_next      = 1'b0;
      started_next    = 1'b0;
      bit_index_next  = 4'd0;
      wait_count_next = END_WAIT;
      if (stored_frame != shift_word) begin
        stored_frame_next = shift_word;
        new_flag_next     = 1'b1;
        event_next        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      wait_count   <= END_WAIT;
      started      <= 1'b0;
      bit_index    <= 4'd0;
      shift_word   <= '0;
      stored_frame <= '0;
      new_flag     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= item_take || (res_valid && !res_ready);
      if (item_take) begin
        armed        <= armed_next;
        wait_count   <= wait_count_next;
        started      <= started_next;
        bit_index    <= bit_index_next;
        shift_word   <= shift_word_next;
        stored_frame <= stored_frame_next;
        new_flag     <= new_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res.frame_event <= event_next;
      res.command     <= stored_frame_next[5:0];
      res.address     <= stored_frame_next[10:6];
      res.toggle_bit  <= stored_frame_next[11];
      res.new_data    <= new_flag_next;
      res.busy_res    <= armed_next;
    end
  end

  a_started_armed: assert property (@(posedge clk) disable iff (rst)
    started |-> armed)
    else $error("started set while not armed");

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= FRAME_BITS)
    else $error("bit index past frame length");

  a_event_sets_flag: assert property (@(posedge clk) disable iff (rst)
    item_take && event_next |=> res.new_data && !res.busy_res)
    else $error("frame event without new data or still busy");

  a_noise_idles: assert property (@(posedge clk) disable iff (rst)
    item_take && armed && !started && wait_count <= 6'd1 && item.pin_level
    |=> !armed && !started)
    else $error("noise start bit did not return to idle");

endmodule

// ===== hw/rtl/rc5_ir_frame_receiver.sv =====
`timescale 1ns / 1ps

// RC-5 infrared receiver driven by sampling ticks.
// Input channel (in_valid/in_ready): one request per sampling tick with the
// pin level (active low), a falling-edge flag and a read acknowledge.
// Output channel (out_valid/out_ready): exactly one result per tick, in
// order, giving the frame event pulse, the stored frame split into command,
// address and toggle bit, the new-data flag and the busy flag.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes the
// initial, half-bit and bit wait registers (index 0..2); index 3 is ignored.
// cfg_ready is always high; write only while no tick is in flight.
// From input accept to result valid a tick passes an input register, then
// the state update feeding the result register. Throughput is one tick
// per cycle while out_ready stays high, set by the counter and shift update.
// Reset (synchronous) empties both registers, returns to idle with no
// stored frame and loads the wait registers with 22, 8 and 18.
// When out_ready is low the result is held; the input register still takes
// one more request, after which in_ready drops until the result drains.

module rc5_ir_frame_receiver
  import rc5_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       pin_level,
  input  logic       falling_edge,
  input  logic       read_ack,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       frame_event,
  output logic [5:0] command,
  output logic [4:0] address,
  output logic       toggle_bit,
  output logic       new_data,
  output logic       busy_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_item   = '{pin_level: pin_level, falling_edge: falling_edge,
                       read_ack: read_ack};

  rc5_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rc5_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  rc5_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign frame_event = res.frame_event;
  assign command     = res.command;
  assign address     = res.address;
  assign toggle_bit  = res.toggle_bit;
  assign new_data    = res.new_data;
  assign busy_res    = res.busy_res;

endmodule

// ===== tb/rc5_ir_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

module rc5_ir_frame_receiver_tb;
  import rc5_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int TICK_LIMIT = 200000;
  localparam int HOLD_AFTER = 150;
  localparam int HOLD_CYCLES = 40;

  // tracks the receiver state and the per-tick outputs still owed
  class rc5_rx_scoreboard;
    cfg_t                timing;
    logic                armed;
    logic [5:0]          wait_count;
    logic                started;
    logic [3:0]          bit_index;
    logic [FRAME_W-1:0]  shift_word;
    logic [FRAME_W-1:0]  stored_frame;
    logic                new_flag;
    result_t             replies_due[$];
    int                  mismatches;
    int                  checked;

    function new();
      timing.initial_wait  = INITIAL_WAIT_RST;
      timing.half_bit_wait = HALF_BIT_WAIT_RST;
      timing.bit_wait      = BIT_WAIT_RST;
      armed        = 1'b0;
      wait_count   = END_WAIT;
      started      = 1'b0;
      bit_index    = '0;
      shift_word   = '0;
      stored_frame = '0;
      new_flag     = 1'b0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function void load_reg(logic [1:0] idx, logic [5:0] val);
      case (idx)
        REG_INITIAL_WAIT:  timing.initial_wait = val;
        REG_HALF_BIT_WAIT: timing.half_bit_wait = val;
        REG_BIT_WAIT:      timing.bit_wait = val;
        default: ;
      endcase
    endfunction

    function result_t decode_tick(item_t t);
      result_t r;
      logic    fresh;
      fresh = 1'b0;
      if (t.read_ack) new_flag = 1'b0;
      if (!armed) begin
        if (t.falling_edge) begin
          armed = 1'b1;
          wait_count = timing.initial_wait;
        end
      end else if (wait_count > 6'd1) begin
        wait_count = wait_count - 6'd1;
      end else if (!started) begin
        // start bit high means the edge was a glitch
        if (t.pin_level) begin
          armed = 1'b0;
          wait_count = timing.initial_wait;
        end else begin
          wait_count = timing.half_bit_wait;
          started = 1'b1;
          bit_index = '0;
          shift_word = '0;
        end
      end else if (bit_index < FRAME_BITS) begin
        shift_word = {shift_word[FRAME_W-2:0], t.pin_level};
        wait_count = timing.bit_wait;
        bit_index = bit_index + 4'd1;
      end else begin
        armed = 1'b0;
        started = 1'b0;
        bit_index = '0;
        wait_count = END_WAIT;
        if (stored_frame != shift_word) begin
          stored_frame = shift_word;
          new_flag = 1'b1;
          fresh = 1'b1;
        end
      end
      r.frame_event = fresh;
      r.command     = stored_frame[5:0];
      r.address     = stored_frame[10:6];
      r.toggle_bit  = stored_frame[11];
      r.new_data    = new_flag;
      r.busy_res    = armed;
      return r;
    endfunction

    function void take_tick(item_t t);
      replies_due.push_back(decode_tick(t));
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      if (mismatches <= 30)
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
    endtask

    task match_tick(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = replies_due.pop_front();
      if (got.frame_event !== want.frame_event)
        report("frame_event", got.frame_event, want.frame_event);
      if (got.command !== want.command) report("command", got.command, want.command);
      if (got.address !== want.address) report("address", got.address, want.address);
      if (got.toggle_bit !== want.toggle_bit)
        report("toggle_bit", got.toggle_bit, want.toggle_bit);
      if (got.new_data !== want.new_data) report("new_data", got.new_data, want.new_data);
      if (got.busy_res !== want.busy_res) report("busy_res", got.busy_res, want.busy_res);
      checked++;
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       pin_level;
  logic       falling_edge;
  logic       read_ack;
  logic       out_valid;
  logic       out_ready;
  logic       frame_event;
  logic [5:0] command;
  logic [4:0] address;
  logic       toggle_bit;
  logic       new_data;
  logic       busy_res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  rc5_rx_scoreboard rx_board;
  logic             hold_outputs;
  bit               send_quick;
  int               ticks_sent;
  int               cycles;

  rc5_ir_frame_receiver DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pin_level(pin_level), .falling_edge(falling_edge), .read_ack(read_ack),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_event(frame_event), .command(command), .address(address),
    .toggle_bit(toggle_bit), .new_data(new_data), .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > TICK_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random back-pressure per result, plus the long hold
  initial begin
    int      gap;
    bit      quick;
    result_t got;
    gap = 0;
    quick = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && out_ready) begin
          got.frame_event = frame_event;
          got.command     = command;
          got.address     = address;
          got.toggle_bit  = toggle_bit;
          got.new_data    = new_data;
          got.busy_res    = busy_res;
          rx_board.match_tick(got);
          gap = quick ? 0 : $urandom_range(0, 4);
          if ($urandom_range(0, 63) == 0) quick = !quick;
        end else if (gap > 0) begin
          gap--;
        end
        out_ready <= (gap == 0) && !hold_outputs;
      end
    end
  end

  // stall the result side once for a long stretch so the input backs up
  initial begin
    hold_outputs <= 1'b0;
    @(posedge clk);
    while (rx_board.checked < HOLD_AFTER) @(posedge clk);
    hold_outputs <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_outputs <= 1'b0;
  end

  task send_tick(item_t t);
    int gap;
    gap = send_quick ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 63) == 0) send_quick = !send_quick;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    pin_level    <= t.pin_level;
    falling_edge <= t.falling_edge;
    read_ack     <= t.read_ack;
    do @(posedge clk); while (!(in_valid && in_ready));
    rx_board.take_tick(t);
    ticks_sent++;
  endtask

  task send_noise(int n);
    item_t t;
    repeat (n) begin
      t = item_t'(3'($urandom_range(0, 7)));
      send_tick(t);
    end
  endtask

  // one frame laid out against the current timing; noisy stops at the start bit
  task send_frame(logic [FRAME_W-1:0] word, bit noisy, bit ack_at_end, bit edge_storm);
    item_t t;
    int    iw;
    int    hw;
    int    bw;
    int    last;
    int    slot;
    while (rx_board.armed) begin
      t = item_t'(3'($urandom_range(0, 7)));
      t.falling_edge = 1'b0;
      // a stray arm sees a high start bit and ends quickly
      if (!rx_board.started) t.pin_level = 1'b1;
      send_tick(t);
    end
    iw = rx_board.timing.initial_wait;
    hw = rx_board.timing.half_bit_wait;
    bw = rx_board.timing.bit_wait;
    last = noisy ? iw : iw + hw + int'(FRAME_BITS) * bw;
    for (int k = 0; k <= last; k++) begin
      t.falling_edge = (k == 0) || edge_storm || ($urandom_range(0, 7) == 0);
      t.read_ack = (k == last) ? ack_at_end : ($urandom_range(0, 15) == 0);
      t.pin_level = $urandom_range(0, 1);
      if (k == iw) begin
        t.pin_level = noisy;
      end else if (k >= iw + hw && k < last && (k - iw - hw) % bw == 0) begin
        slot = (k - iw - hw) / bw;
        t.pin_level = word[FRAME_W - 1 - slot];
      end
      send_tick(t);
    end
  endtask

  task drain;
    in_valid <= 1'b0;
    while (rx_board.replies_due.size() != 0) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    rx_board.load_reg(idx, val);
  endtask

  task set_timing(int iw, int hw, int bw);
    write_reg(REG_UNUSED, 6'($urandom_range(0, 63)));
    write_reg(REG_INITIAL_WAIT, 6'(iw));
    write_reg(REG_HALF_BIT_WAIT, 6'(hw));
    write_reg(REG_BIT_WAIT, 6'(bw));
    cfg_valid <= 1'b0;
  endtask

  task run_random(int budget);
    int                 start;
    int                 pick;
    bit                 long_bits;
    logic [FRAME_W-1:0] word;
    start = ticks_sent;
    long_bits = rx_board.timing.bit_wait > 6'd20;
    while (ticks_sent - start < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send_noise($urandom_range(1, 6));
      end else begin
        // repeats of the stored frame must not raise an event
        word = (pick < 5) ? rx_board.stored_frame : FRAME_W'($urandom_range(0, 4095));
        send_frame(word, long_bits || pick == 2, $urandom_range(0, 1), pick == 9);
      end
    end
  endtask

  initial begin
    rx_board = new();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    pin_level    <= 1'b1;
    falling_edge <= 1'b0;
    read_ack     <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_INITIAL_WAIT;
    cfg_data     <= '0;
    send_quick   = 1'b0;
    ticks_sent   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // every field combination at reset timing, then settle the frame it starts
    for (int c = 0; c < 8; c++) send_tick(item_t'(3'(c)));
    send_frame(12'hfff, 1'b1, 1'b0, 1'b0);
    drain();

    // shortest half-bit and bit waits: all ones, edges ignored while busy, read on the storing tick
    set_timing(2, 1, 1);
    send_frame(12'hfff, 1'b0, 1'b1, 1'b1);
    send_frame(12'h000, 1'b1, 1'b0, 1'b0);
    send_frame(12'h555, 1'b0, 1'b0, 1'b0);
    drain();

    set_timing(63, 63, 63);
    run_random(100);
    drain();
    set_timing(63, 63, 2);
    run_random(120);
    drain();
    set_timing(2, 63, 1);
    run_random(100);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_timing($urandom_range(2, 8), $urandom_range(1, 6), $urandom_range(1, 5));
      run_random(70);
      drain();
    end
    set_timing($urandom_range(2, 63), $urandom_range(1, 20), $urandom_range(1, 4));
    run_random(70);
    drain();

    repeat (4) @(posedge clk);
    if (rx_board.replies_due.size() != 0)
      rx_board.report("results left over", rx_board.replies_due.size(), 0);
    if (rx_board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
